// File: design/jssm_pkg.sv
// ----------------------------------------------------------------------------
// jssm_pkg
// Types, constants and helpers of the joystick string servo mixer.
// ----------------------------------------------------------------------------
package jssm_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_GAIN_X,
    ST_GAIN_Y,
    ST_LSQ_X,
    ST_LSQ_Y,
    ST_LROOT_LD,
    ST_LROOT,
    ST_RSQ_X,
    ST_RSQ_Y,
    ST_RROOT_LD,
    ST_RROOT,
    ST_PULSE_R,
    ST_PULSE_L,
    ST_PULSE_END,
    ST_OUT
  } state_e;

  // Event kinds
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;

  // Trim buttons
  localparam logic [7:0] BTN_X_INC = 8'd0;
  localparam logic [7:0] BTN_Y_INC = 8'd1;
  localparam logic [7:0] BTN_Y_DEC = 8'd2;
  localparam logic [7:0] BTN_X_DEC = 8'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRIM_STEP   = 2'd0;
  localparam logic [1:0] CFG_TRIM_X_BASE = 2'd1;
  localparam logic [1:0] CFG_TRIM_Y_BASE = 2'd2;
  localparam logic [1:0] CFG_SERVO_EN    = 2'd3;

  // Port widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 23;

  // Datapath widths
  localparam int unsigned MulW    = 26;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned SqW     = 48;
  localparam int unsigned RootW   = 24;
  localparam int unsigned SqSteps = SqW / 2;
  localparam int unsigned SqCntW  = $clog2(SqSteps);

  // Geometry in Q16
  localparam logic signed [MulW-1:0] STICK_GAIN   = 26'sd185369;
  localparam logic signed [MulW-1:0] PULSE_GAIN   = 26'sd1000;
  localparam logic signed [MulW-1:0] LEFT_X0      = 26'sd917504;
  localparam logic signed [MulW-1:0] RIGHT_X0     = 26'sd720896;
  localparam logic signed [MulW-1:0] STRING_Y0    = 26'sd458752;
  localparam logic [RootW-1:0]       REST_LEFT    = 24'd1025800;
  localparam logic [RootW-1:0]       REST_RIGHT   = 24'd854484;
  localparam logic signed [ProdW-1:0] ROUND_HALF  = 52'sd32768;
  localparam logic [11:0]            PULSE_CENTRE = 12'd1500;
  localparam logic signed [MulW-1:0] PULSE_OFS    = 26'sd1500;
  localparam logic signed [MulW-1:0] PULSE_MAX    = 26'sd4095;
  localparam logic signed [MulW-1:0] S24_MAX      = 26'sd8388607;
  localparam logic signed [MulW-1:0] S24_MIN      = -26'sd8388608;

  // Saturate to signed 24 bit
  function automatic logic signed [23:0] sat24(input logic signed [MulW-1:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < S24_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Magnitude of a value known to stay within 24 bits
  function automatic logic [RootW-1:0] abs24(input logic signed [MulW-1:0] v);
    logic signed [MulW-1:0] m;
    m = v[MulW-1] ? -v : v;
    return m[RootW-1:0];
  endfunction

  // Round the scaled length difference and centre it, saturated to 0..4095
  function automatic logic [11:0] pulse_of(input logic signed [ProdW-1:0] prod);
    logic signed [ProdW-1:0] psum;
    logic signed [MulW-1:0]  p;
    logic [11:0]             r;
    psum = prod + ROUND_HALF;
    p    = $signed(psum[MulW+15:16]) + PULSE_OFS;
    if (p < 0) begin
      r = 12'd0;
    end else if (p > PULSE_MAX) begin
      r = 12'd4095;
    end else begin
      r = p[11:0];
    end
    return r;
  endfunction

endpackage

// File: design/joystick_string_servo_mixer_top.sv
// ----------------------------------------------------------------------------
// joystick_string_servo_mixer_top
// Joystick events to two string servo pulse widths, with button trims.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: index, level
//                                                     tuser: kind
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: right, left,
//                                                     trim x, trim y
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// An item runs from acceptance to a loaded result through two 24-step square
// roots on one root unit and eight passes through one shared 26x26 multiplier,
// one item at a time; the next item is taken once the sequencer is back in idle.
// Reset clears the sequencer, the stored axes, trims and registers to their
// defaults. A stalled result holds in the output register while the next
// item is accepted; the sequencer waits at its end until that register frees.
// ----------------------------------------------------------------------------
module joystick_string_servo_mixer_top #(
  parameter int unsigned AXIS_PAIRS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // event_index [7:0], event_level [23:8]
  input  logic [jssm_pkg::InDataW-1:0]  s_axis_tdata,
  // event_kind [1:0]
  input  logic [jssm_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // right_pulse_us [11:0], left_pulse_us [23:12], trim_x_now [47:24],
  // trim_y_now [71:48]
  output logic [jssm_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [jssm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jssm_pkg::CfgDataW-1:0] cfg_data_i
);
  import jssm_pkg::*;

  localparam int unsigned AxisN  = 2 * AXIS_PAIRS;
  localparam int unsigned AxisW  = $clog2(AxisN);
  localparam logic [7:0]  AxisNum = 8'(AxisN);

  state_e state_q, state_d;

  // Configuration
  logic [15:0]        step_q;
  logic signed [22:0] base_x_q, base_y_q;
  logic               enable_q;

  // Event state
  logic signed [15:0] axis_q [AxisN];
  logic signed [23:0] ofs_x_q, ofs_y_q;

  // Latched item
  logic [1:0]         kind_q;
  logic [7:0]         index_q;
  logic signed [15:0] level_q;

  // Datapath
  logic signed [23:0]      tx_q, ty_q, x_q, y_q;
  logic signed [ProdW-1:0] prod_q;
  logic [SqW-1:0]          acc_q;
  logic [RootW-1:0]        root_l_q, root_r_q;
  logic [11:0]             pulse_r_q, pulse_l_q;
  logic [SqW-1:0]          sq_n_q, sq_r_q, sq_bit_q;
  logic [SqCntW-1:0]       sq_cnt_q;

  // Output register
  logic                    m_valid_q;
  logic [OutDataW-1:0]     m_data_q;

  logic                    in_fire, out_load;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [MulW-1:0]  step_s, ofs_sum, tx_sum, ty_sum, x_sum, y_sum;
  logic signed [MulW-1:0]  x_w, y_w, g_w;
  logic signed [ProdW-1:0] g_sum;
  logic [RootW-1:0]        lax, rax, ady;
  logic [SqW:0]            sq_try;
  logic                    sq_ge;
  logic [SqW-1:0]          sq_n_nx, sq_r_nx;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Combinational datapath
  // --------------------------------------------------------------------------
  always_comb begin
    step_s = $signed({10'd0, step_q});
    unique case (index_q)
      BTN_X_INC: ofs_sum = {{2{ofs_x_q[23]}}, ofs_x_q} + step_s;
      BTN_X_DEC: ofs_sum = {{2{ofs_x_q[23]}}, ofs_x_q} - step_s;
      BTN_Y_INC: ofs_sum = {{2{ofs_y_q[23]}}, ofs_y_q} + step_s;
      BTN_Y_DEC: ofs_sum = {{2{ofs_y_q[23]}}, ofs_y_q} - step_s;
      default:   ofs_sum = '0;
    endcase
    tx_sum = {{3{base_x_q[22]}}, base_x_q} + {{2{ofs_x_q[23]}}, ofs_x_q};
    ty_sum = {{3{base_y_q[22]}}, base_y_q} + {{2{ofs_y_q[23]}}, ofs_y_q};

    // Round the stick gain product back to Q16
    g_sum = prod_q + ROUND_HALF;
    g_w   = $signed(g_sum[MulW+15:16]);
    x_sum = g_w + {{2{tx_q[23]}}, tx_q};
    y_sum = g_w + {{2{ty_q[23]}}, ty_q};

    x_w = {{2{x_q[23]}}, x_q};
    y_w = {{2{y_q[23]}}, y_q};
    lax = abs24(LEFT_X0 + x_w);
    rax = abs24(RIGHT_X0 - x_w);
    ady = abs24(STRING_Y0 - y_w);

    // One step of the root: two bits of the radicand, one bit of the root
    sq_try  = {1'b0, sq_r_q} + {1'b0, sq_bit_q};
    sq_ge   = {1'b0, sq_n_q} >= sq_try;
    sq_n_nx = sq_ge ? sq_n_q - sq_try[SqW-1:0] : sq_n_q;
    sq_r_nx = sq_ge ? (sq_r_q >> 1) + sq_bit_q : sq_r_q >> 1;
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_UPDATE;
      ST_UPDATE:    state_d = ST_GAIN_X;
      ST_GAIN_X:    state_d = ST_GAIN_Y;
      ST_GAIN_Y:    state_d = ST_LSQ_X;
      ST_LSQ_X:     state_d = ST_LSQ_Y;
      ST_LSQ_Y:     state_d = ST_LROOT_LD;
      ST_LROOT_LD:  state_d = ST_LROOT;
      ST_LROOT:     if (sq_cnt_q == '0) state_d = ST_RSQ_X;
      ST_RSQ_X:     state_d = ST_RSQ_Y;
      ST_RSQ_Y:     state_d = ST_RROOT_LD;
      ST_RROOT_LD:  state_d = ST_RROOT;
      ST_RROOT:     if (sq_cnt_q == '0) state_d = ST_PULSE_R;
      ST_PULSE_R:   state_d = ST_PULSE_L;
      ST_PULSE_L:   state_d = ST_PULSE_END;
      ST_PULSE_END: state_d = ST_OUT;
      ST_OUT:       if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (multiplier operands, handshakes)
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_GAIN_X: begin
        mul_a = {{(MulW-16){axis_q[1][15]}}, axis_q[1]};
        mul_b = STICK_GAIN;
      end
      ST_GAIN_Y: begin
        mul_a = {{(MulW-16){axis_q[0][15]}}, axis_q[0]};
        mul_b = STICK_GAIN;
      end
      ST_LSQ_X: begin
        mul_a = $signed({2'b0, lax});
        mul_b = $signed({2'b0, lax});
      end
      ST_LSQ_Y, ST_RSQ_Y: begin
        mul_a = $signed({2'b0, ady});
        mul_b = $signed({2'b0, ady});
      end
      ST_RSQ_X: begin
        mul_a = $signed({2'b0, rax});
        mul_b = $signed({2'b0, rax});
      end
      ST_PULSE_R: begin
        mul_a = $signed({2'b0, root_r_q}) - $signed({2'b0, REST_RIGHT});
        mul_b = PULSE_GAIN;
      end
      ST_PULSE_L: begin
        mul_a = $signed({2'b0, root_l_q}) - $signed({2'b0, REST_LEFT});
        mul_b = PULSE_GAIN;
      end
      ST_OUT: out_load = !m_valid_q || m_axis_tready;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      step_q    <= 16'd655;
      base_x_q  <= '0;
      base_y_q  <= '0;
      enable_q  <= 1'b1;
      ofs_x_q   <= '0;
      ofs_y_q   <= '0;
      for (int i = 0; i < AxisN; i++) begin
        axis_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TRIM_STEP:   step_q   <= cfg_data_i[15:0];
          CFG_TRIM_X_BASE: base_x_q <= $signed(cfg_data_i);
          CFG_TRIM_Y_BASE: base_y_q <= $signed(cfg_data_i);
          CFG_SERVO_EN:    enable_q <= cfg_data_i[0];
          default:         enable_q <= enable_q;
        endcase
      end

      if (state_q == ST_UPDATE) begin
        if (kind_q == KIND_BUTTON) begin
          if (index_q == BTN_X_INC || index_q == BTN_X_DEC) begin
            ofs_x_q <= sat24(ofs_sum);
          end
          if (index_q == BTN_Y_INC || index_q == BTN_Y_DEC) begin
            ofs_y_q <= sat24(ofs_sum);
          end
        end else if (kind_q == KIND_AXIS && index_q < AxisNum) begin
          axis_q[index_q[AxisW-1:0]] <= level_q;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (in_fire) begin
      kind_q  <= s_axis_tuser;
      index_q <= s_axis_tdata[7:0];
      level_q <= $signed(s_axis_tdata[23:8]);
    end

    unique case (state_q)
      ST_GAIN_X: begin
        tx_q <= sat24(tx_sum);
        ty_q <= sat24(ty_sum);
      end
      ST_GAIN_Y: x_q <= sat24(x_sum);
      ST_LSQ_X:  y_q <= sat24(y_sum);
      ST_LSQ_Y, ST_RSQ_Y: acc_q <= prod_q[SqW-1:0];
      ST_LROOT_LD, ST_RROOT_LD: begin
        sq_n_q   <= acc_q + prod_q[SqW-1:0];
        sq_r_q   <= '0;
        sq_bit_q <= {2'b01, {(SqW-2){1'b0}}};
        sq_cnt_q <= SqCntW'(SqSteps - 1);
      end
      ST_LROOT, ST_RROOT: begin
        sq_n_q   <= sq_n_nx;
        sq_r_q   <= sq_r_nx;
        sq_bit_q <= sq_bit_q >> 2;
        sq_cnt_q <= sq_cnt_q - 1'b1;
        if (sq_cnt_q == '0) begin
          if (state_q == ST_LROOT) begin
            root_l_q <= sq_r_nx[RootW-1:0];
          end else begin
            root_r_q <= sq_r_nx[RootW-1:0];
          end
        end
      end
      ST_PULSE_L:   pulse_r_q <= pulse_of(prod_q);
      ST_PULSE_END: pulse_l_q <= pulse_of(prod_q);
      default:      acc_q <= acc_q;
    endcase

    if (out_load) begin
      m_data_q[11:0]  <= enable_q ? pulse_r_q : PULSE_CENTRE;
      m_data_q[23:12] <= enable_q ? pulse_l_q : PULSE_CENTRE;
      m_data_q[47:24] <= tx_q;
      m_data_q[71:48] <= ty_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: design/jssm_checker.sv
// ----------------------------------------------------------------------------
// jssm_checker
// Port-level checks on the joystick string servo mixer, bound to the top.
// ----------------------------------------------------------------------------
module jssm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [jssm_pkg::OutDataW-1:0] m_axis_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

  // A new result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result loaded while still busy");

  // Returning to idle always leaves a result behind
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("item finished without a result");

endmodule

bind joystick_string_servo_mixer_top jssm_checker u_jssm_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joystick string servo mixer: random joystick
// events and register settings go in, and every pulse and trim item that
// comes out is compared against a fixed-point servo geometry predictor.
// ----------------------------------------------------------------------------
module tb;
  import jssm_pkg::*;

  localparam int          STICK_PAIRS = 3;
  localparam logic [1:0]  KIND_OTHER  = 2'd2;
  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam longint      TRIM_HI     = 64'sd8388607;
  localparam longint      TRIM_LO     = -64'sd8388608;
  localparam longint      GAIN_Q16    = 64'sd185369;
  localparam longint      ONE_Q16     = 64'sd65536;
  localparam longint      HALF_Q16    = 64'sd32768;
  localparam longint      LEFT_ANCHOR = 64'sd14;
  localparam longint      RIGHT_ANCHOR = 64'sd11;
  localparam longint      ANCHOR_Y    = 64'sd7;
  localparam longint      CENTRE_US   = 64'sd1500;
  localparam longint      US_SCALE    = 64'sd1000;
  localparam int          WATCHDOG_CYCLES = 2000;

  typedef struct {
    logic [11:0]        right_us;
    logic [11:0]        left_us;
    logic signed [23:0] trim_x;
    logic signed [23:0] trim_y;
  } servo_result_t;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned rem, root, probe;
    rem   = n;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint string_len(longint dx, longint dy);
    return int_sqrt(longint'(dx * dx + dy * dy));
  endfunction

  // round the length change to microseconds about the centre, saturated
  function automatic logic [11:0] pulse_width(longint len, longint rest);
    longint p;
    p = (((len - rest) * US_SCALE + HALF_Q16) >>> 16) + CENTRE_US;
    p = clamp(p, 0, 4095);
    return p[11:0];
  endfunction

  class servo_scoreboard;
    longint             step_q16;
    longint             x_base;
    longint             y_base;
    bit                 enabled;
    logic signed [15:0] axis_level [2*STICK_PAIRS];
    longint             x_offset;
    longint             y_offset;
    longint             rest_left;
    longint             rest_right;
    servo_result_t      pending [$];
    int                 errors;

    function new();
      step_q16 = 655;
      x_base   = 0;
      y_base   = 0;
      enabled  = 1'b1;
      foreach (axis_level[i]) axis_level[i] = '0;
      x_offset   = 0;
      y_offset   = 0;
      rest_left  = int_sqrt(64'd245 << 32);
      rest_right = int_sqrt(64'd170 << 32);
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [22:0] val);
      case (idx)
        CFG_TRIM_STEP:   step_q16 = longint'(val[15:0]);
        CFG_TRIM_X_BASE: x_base = longint'($signed(val));
        CFG_TRIM_Y_BASE: y_base = longint'($signed(val));
        CFG_SERVO_EN:    enabled = val[0];
        default: ;
      endcase
    endfunction

    function void note_event(logic [1:0] kind, logic [7:0] idx, logic signed [15:0] level);
      longint        tx, ty, gx, gy, x, y;
      servo_result_t r;
      if (kind == KIND_BUTTON) begin
        case (idx)
          BTN_X_INC: x_offset = clamp(x_offset + step_q16, TRIM_LO, TRIM_HI);
          BTN_Y_INC: y_offset = clamp(y_offset + step_q16, TRIM_LO, TRIM_HI);
          BTN_Y_DEC: y_offset = clamp(y_offset - step_q16, TRIM_LO, TRIM_HI);
          BTN_X_DEC: x_offset = clamp(x_offset - step_q16, TRIM_LO, TRIM_HI);
          default: ;
        endcase
      end else if (kind == KIND_AXIS) begin
        if (idx < 2 * STICK_PAIRS) axis_level[idx] = level;
      end
      tx = clamp(x_base + x_offset, TRIM_LO, TRIM_HI);
      ty = clamp(y_base + y_offset, TRIM_LO, TRIM_HI);
      // stick x follows axis 1, stick y follows axis 0
      gx = (longint'(axis_level[1]) * GAIN_Q16 + HALF_Q16) >>> 16;
      gy = (longint'(axis_level[0]) * GAIN_Q16 + HALF_Q16) >>> 16;
      x  = clamp(gx + tx, TRIM_LO, TRIM_HI);
      y  = clamp(gy + ty, TRIM_LO, TRIM_HI);
      if (enabled) begin
        r.right_us = pulse_width(string_len(RIGHT_ANCHOR * ONE_Q16 - x,
                                            ANCHOR_Y * ONE_Q16 - y), rest_right);
        r.left_us  = pulse_width(string_len(LEFT_ANCHOR * ONE_Q16 + x,
                                            ANCHOR_Y * ONE_Q16 - y), rest_left);
      end else begin
        r.right_us = 12'd1500;
        r.left_us  = 12'd1500;
      end
      r.trim_x = tx[23:0];
      r.trim_y = ty[23:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      servo_result_t want;
      if (pending.size() == 0) begin
        $error("result item arrived with no event outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (d[11:0] !== want.right_us) begin
        $error("right_pulse_us: expected %0d, got %0d", want.right_us, d[11:0]);
        errors++;
      end
      if (d[23:12] !== want.left_us) begin
        $error("left_pulse_us: expected %0d, got %0d", want.left_us, d[23:12]);
        errors++;
      end
      if (d[47:24] !== want.trim_x) begin
        $error("trim_x_now: expected %0d, got %0d", want.trim_x, $signed(d[47:24]));
        errors++;
      end
      if (d[71:48] !== want.trim_y) begin
        $error("trim_y_now: expected %0d, got %0d", want.trim_y, $signed(d[71:48]));
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic [InUserW-1:0]    s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  servo_scoreboard sb;
  bit              idle_on;
  int              stall_left;
  int              quiet_cycles;

  joystick_string_servo_mixer_top #(
    .AXIS_PAIRS(STICK_PAIRS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (idle_on && stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // end the run if no item moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [7:0] idx,
                            input logic [15:0] level);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {level, idx};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(kind, idx, level);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [22:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input longint step, input longint xb, input longint yb,
                            input bit en);
    write_reg(CFG_TRIM_STEP, 23'(step));
    write_reg(CFG_TRIM_X_BASE, 23'(xb));
    write_reg(CFG_TRIM_Y_BASE, 23'(yb));
    write_reg(CFG_SERVO_EN, 23'(en));
    cfg_valid_i <= 1'b0;
  endtask

  // mostly stick moves and trim button runs, the rest noise
  task automatic run_events(input int count, input bit pause_midway);
    int          sent, pick, run, k;
    logic [7:0]  idx;
    logic [15:0] level;
    sent = 0;
    while (sent < count) begin
      if (pause_midway && sent >= count / 2 && sent < count / 2 + 1) wait_drained();
      pick  = $urandom_range(0, 99);
      level = 16'($urandom);
      if (pick < 40) begin
        if ($urandom_range(0, 7) == 0) level = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        send_event(KIND_AXIS, 8'($urandom_range(0, 1)), level);
        sent++;
      end else if (pick < 50) begin
        send_event(KIND_AXIS, 8'($urandom_range(2, 2 * STICK_PAIRS - 1)), level);
        sent++;
      end else if (pick < 80) begin
        idx = 8'($urandom_range(0, 3));
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 6);
        if (run > count - sent) run = count - sent;
        for (k = 0; k < run; k++) begin
          send_event(KIND_BUTTON, idx, $urandom_range(0, 1) ? 16'($urandom) : 16'h0000);
        end
        sent += run;
      end else begin
        case ($urandom_range(0, 2))
          0: send_event(KIND_BUTTON, 8'($urandom_range(4, 255)), level);
          1: send_event(KIND_AXIS, 8'($urandom_range(2 * STICK_PAIRS, 255)), level);
          default: send_event($urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE,
                              8'($urandom), level);
        endcase
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    sb            = new();
    idle_on       = 1'b1;
    stall_left    = 0;
    quiet_cycles  = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stick extremes, every trim button, ignored buttons, axes and kinds
    send_event(KIND_AXIS, 8'd0, 16'h7FFF);
    send_event(KIND_AXIS, 8'd1, 16'h8000);
    send_event(KIND_AXIS, 8'd0, 16'h8000);
    send_event(KIND_AXIS, 8'd1, 16'h7FFF);
    send_event(KIND_BUTTON, BTN_X_INC, 16'h0001);
    send_event(KIND_BUTTON, BTN_X_INC, 16'h0000);
    send_event(KIND_BUTTON, BTN_Y_INC, 16'hFFFF);
    send_event(KIND_BUTTON, BTN_Y_DEC, 16'h0000);
    send_event(KIND_BUTTON, BTN_X_DEC, 16'h7FFF);
    send_event(KIND_BUTTON, 8'd4, 16'h0001);
    send_event(KIND_BUTTON, 8'd255, 16'h8000);
    send_event(KIND_AXIS, 8'd5, 16'd12345);
    send_event(KIND_AXIS, 8'd6, 16'hFFFF);
    send_event(KIND_AXIS, 8'd255, 16'h0001);
    send_event(KIND_OTHER, 8'd0, 16'd100);
    send_event(KIND_SPARE, 8'd255, 16'h8000);
    send_event(KIND_AXIS, 8'd2, 16'hFFF9);
    send_event(KIND_AXIS, 8'd0, 16'h0000);
    send_event(KIND_AXIS, 8'd1, 16'h0000);
    wait_drained();

    set_config(65535, 4194303, -4194304, 1'b1);
    run_events(185, 1'b0);
    set_config(0, -4194304, 4194303, 1'b1);
    run_events(185, 1'b1);
    set_config($urandom_range(0, 65535), longint'($urandom_range(0, 8388607)) - 4194304,
               longint'($urandom_range(0, 8388607)) - 4194304, 1'b0);
    run_events(185, 1'b0);
    set_config($urandom_range(0, 65535), longint'($urandom_range(0, 8388607)) - 4194304,
               longint'($urandom_range(0, 8388607)) - 4194304, 1'b1);
    run_events(185, 1'b1);
    idle_on = 1'b0;
    set_config(655, 0, 0, 1'b1);
    run_events(185, 1'b0);

    repeat (100) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d result items never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/jssm_pkg.sv
design/joystick_string_servo_mixer_top.sv
design/jssm_checker.sv
bench/tb.sv
